### design/indexed_list_table_engine_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the indexed list table engine
// Shared property wrappers used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_TABLE_ENGINE_TOP_MACROS_SVH
`define INDEXED_LIST_TABLE_ENGINE_TOP_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ILTE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define ILTE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/ilte_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list table engine package
// Widths, operation and status codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package ilte_pkg;

  // Store geometry.
  localparam int STORE_DEPTH = 16;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  // Field widths.
  localparam int DATA_W = 32;
  localparam int OP_W   = 4;
  localparam int POS_W  = 4;
  localparam int CAP_W  = 5;
  localparam int ST_W   = 2;
  localparam int LEN_W  = 5;

  // Common width for compares, with headroom for a pointer plus three.
  localparam int WIDE_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 2;

  // Stream words, rounded up to whole bytes.
  localparam int IN_BITS  = OP_W + POS_W + DATA_W;
  localparam int OUT_BITS = DATA_W + ST_W + LEN_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD  = OUT_W - OUT_BITS;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_APPEND  = 4'd0,
    OP_INSERT  = 4'd1,
    OP_DELETE  = 4'd2,
    OP_GET     = 4'd3,
    OP_SET     = 4'd4,
    OP_MAX     = 4'd5,
    OP_MIN     = 4'd6,
    OP_SUM     = 4'd7,
    OP_REVERSE = 4'd8
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Read address source.
  typedef enum logic [2:0] {
    RD_POS,
    RD_PTR,
    RD_PTR_INC,
    RD_PTR_DEC,
    RD_HI
  } rd_t;

  // Write port action (a pending move write takes precedence).
  typedef enum logic [2:0] {
    WR_NONE,
    WR_APPEND,
    WR_POS_VAL,
    WR_PTR_RDATA,
    WR_HI_TMP
  } wr_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_POS,
    PTR_CNT,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC
  } ptr_t;

  typedef enum logic [1:0] {
    HI_HOLD,
    HI_CNT,
    HI_DEC
  } hi_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    rd_t  rd;
    wr_t  wr;
    logic mv;
    logic agg;
    logic acc_ld;
    logic tmp_ld;
    logic st_ld;
    ptr_t ptr;
    hi_t  hi;
    cnt_t cnt;
    logic finish;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    op_t     op;
    status_t code;
    logic    ins_more;
    logic    del_more;
    logic    agg_more;
    logic    rev_more;
    logic    rev_next;
    logic    out_free;
  } stat_t;

endpackage

`default_nettype wire

### design/ilte_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ilte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/ilte_datapath.sv
// ----------------------------------------------------------------------------
// Indexed list table engine datapath
// Entry store, length, pointers, accumulator and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ilte_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire ilte_pkg::cmd_t                 cmd,
  output ilte_pkg::stat_t                     stat,
  input  wire logic [ilte_pkg::IN_W-1:0]      in_data,
  input  wire logic                           cap_we,
  input  wire logic [ilte_pkg::CAP_W-1:0]     cap_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [ilte_pkg::OUT_W-1:0]     out_data
);

  localparam int IDX_W  = ilte_pkg::IDX_W;
  localparam int CNT_W  = ilte_pkg::CNT_W;
  localparam int WIDE_W = ilte_pkg::WIDE_W;
  localparam int DATA_W = ilte_pkg::DATA_W;
  localparam int OP_W   = ilte_pkg::OP_W;
  localparam int POS_W  = ilte_pkg::POS_W;

  // Latched request.
  ilte_pkg::op_t            op_q;
  logic [POS_W-1:0]         pos_q;
  logic [DATA_W-1:0]        val_q;

  // List state and walk pointers.
  logic [CNT_W-1:0]         cnt_q;
  logic [ilte_pkg::CAP_W-1:0] cap_q;
  logic [CNT_W-1:0]         ptr_q;
  logic [CNT_W-1:0]         hi_q;

  // Working registers.
  logic [DATA_W-1:0]        acc_q;
  logic [DATA_W-1:0]        tmp_q;
  ilte_pkg::status_t        st_q;
  logic                     mv_pend;
  logic [IDX_W-1:0]         mv_addr;
  logic                     agg_pend;
  logic                     agg_first;

  // Output register.
  logic [DATA_W-1:0]        out_result;
  ilte_pkg::status_t        out_status;
  logic [ilte_pkg::LEN_W-1:0] out_len;

  // Store ports.
  logic                     we;
  logic [IDX_W-1:0]         waddr;
  logic [DATA_W-1:0]        wdata;
  logic [WIDE_W-1:0]        raddr_w;
  logic [DATA_W-1:0]        rdata;

  // Widened views for compares and address arithmetic.
  logic [WIDE_W-1:0]        pos_w;
  logic [WIDE_W-1:0]        cnt_w;
  logic [WIDE_W-1:0]        cap_w;
  logic [WIDE_W-1:0]        ptr_w;
  logic [WIDE_W-1:0]        hi_w;
  logic [WIDE_W-1:0]        hi_m1_w;
  logic                     full;
  ilte_pkg::status_t        code;
  logic                     take_new;

  assign pos_w   = WIDE_W'(pos_q);
  assign cnt_w   = WIDE_W'(cnt_q);
  assign cap_w   = WIDE_W'(cap_q);
  assign ptr_w   = WIDE_W'(ptr_q);
  assign hi_w    = WIDE_W'(hi_q);
  assign hi_m1_w = hi_w - WIDE_W'(1);

  // The list is full at the configured capacity or the store depth.
  assign full = (cnt_w >= cap_w) || (cnt_w >= WIDE_W'(ilte_pkg::STORE_DEPTH));

  // Error check for the latched request.
  always_comb begin
    code = ilte_pkg::ST_OK;
    case (op_q)
      ilte_pkg::OP_APPEND: begin
        if (full) code = ilte_pkg::ST_FULL;
      end
      ilte_pkg::OP_INSERT: begin
        if (full) code = ilte_pkg::ST_FULL;
        else if (pos_w > cnt_w) code = ilte_pkg::ST_RANGE;
      end
      ilte_pkg::OP_DELETE, ilte_pkg::OP_GET, ilte_pkg::OP_SET: begin
        if (pos_w >= cnt_w) code = ilte_pkg::ST_RANGE;
      end
      ilte_pkg::OP_MAX, ilte_pkg::OP_MIN: begin
        if (cnt_q == '0) code = ilte_pkg::ST_EMPTY;
      end
      default: code = ilte_pkg::ST_OK;
    endcase
  end

  // Status toward the controller.
  assign take_new = !out_valid || out_ready;
  always_comb begin
    stat.op       = op_q;
    stat.code     = code;
    stat.ins_more = ptr_w > pos_w;
    stat.del_more = (ptr_w + WIDE_W'(1)) < cnt_w;
    stat.agg_more = ptr_w < cnt_w;
    stat.rev_more = (ptr_w + WIDE_W'(1)) < hi_w;
    stat.rev_next = (ptr_w + WIDE_W'(3)) < hi_w;
    stat.out_free = take_new;
  end

  // Read address select.
  always_comb begin
    case (cmd.rd)
      ilte_pkg::RD_POS:     raddr_w = pos_w;
      ilte_pkg::RD_PTR:     raddr_w = ptr_w;
      ilte_pkg::RD_PTR_INC: raddr_w = ptr_w + WIDE_W'(1);
      ilte_pkg::RD_PTR_DEC: raddr_w = ptr_w - WIDE_W'(1);
      ilte_pkg::RD_HI:      raddr_w = hi_m1_w;
      default:              raddr_w = ptr_w;
    endcase
  end

  // Write port: a move issued last cycle lands first.
  always_comb begin
    we    = 1'b0;
    waddr = mv_addr;
    wdata = rdata;
    if (mv_pend) begin
      we = 1'b1;
    end else begin
      case (cmd.wr)
        ilte_pkg::WR_APPEND: begin
          we    = 1'b1;
          waddr = cnt_w[IDX_W-1:0];
          wdata = val_q;
        end
        ilte_pkg::WR_POS_VAL: begin
          we    = 1'b1;
          waddr = pos_w[IDX_W-1:0];
          wdata = val_q;
        end
        ilte_pkg::WR_PTR_RDATA: begin
          we    = 1'b1;
          waddr = ptr_w[IDX_W-1:0];
          wdata = rdata;
        end
        ilte_pkg::WR_HI_TMP: begin
          we    = 1'b1;
          waddr = hi_m1_w[IDX_W-1:0];
          wdata = tmp_q;
        end
        default: we = 1'b0;
      endcase
    end
  end

  ilte_ram #(
    .WIDTH(DATA_W),
    .DEPTH(ilte_pkg::STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr_w[IDX_W-1:0]),
    .rdata(rdata)
  );

  // Control registers: length, capacity, pending flags and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_q     <= '0;
      cap_q     <= ilte_pkg::CAP_RESET;
      mv_pend   <= 1'b0;
      agg_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cap_we) cap_q <= cap_data;
      case (cmd.cnt)
        ilte_pkg::CNT_INC: cnt_q <= cnt_q + CNT_W'(1);
        ilte_pkg::CNT_DEC: cnt_q <= cnt_q - CNT_W'(1);
        default:           cnt_q <= cnt_q;
      endcase
      mv_pend  <= cmd.mv;
      agg_pend <= cmd.agg;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= ilte_pkg::op_t'(in_data[OP_W-1:0]);
      pos_q <= in_data[OP_W+POS_W-1:OP_W];
      val_q <= in_data[OP_W+POS_W+DATA_W-1:OP_W+POS_W];
    end
    if (cmd.st_ld) st_q <= code;
    if (cmd.tmp_ld) tmp_q <= rdata;
    mv_addr   <= ptr_w[IDX_W-1:0];
    agg_first <= (ptr_q == '0);

    // Walk pointers.
    case (cmd.ptr)
      ilte_pkg::PTR_POS:  ptr_q <= pos_w[CNT_W-1:0];
      ilte_pkg::PTR_CNT:  ptr_q <= cnt_q;
      ilte_pkg::PTR_ZERO: ptr_q <= '0;
      ilte_pkg::PTR_INC:  ptr_q <= ptr_q + CNT_W'(1);
      ilte_pkg::PTR_DEC:  ptr_q <= ptr_q - CNT_W'(1);
      default:            ptr_q <= ptr_q;
    endcase
    case (cmd.hi)
      ilte_pkg::HI_CNT: hi_q <= cnt_q;
      ilte_pkg::HI_DEC: hi_q <= hi_q - CNT_W'(1);
      default:          hi_q <= hi_q;
    endcase

    // Accumulator: cleared per request, loaded by reads and aggregates.
    if (cmd.st_ld) begin
      acc_q <= '0;
    end else if (cmd.acc_ld) begin
      acc_q <= rdata;
    end else if (agg_pend) begin
      if (op_q == ilte_pkg::OP_SUM) begin
        acc_q <= acc_q + rdata;
      end else if (agg_first) begin
        acc_q <= rdata;
      end else if (op_q == ilte_pkg::OP_MAX) begin
        if ($signed(rdata) > $signed(acc_q)) acc_q <= rdata;
      end else begin
        if ($signed(rdata) < $signed(acc_q)) acc_q <= rdata;
      end
    end

    if (cmd.finish) begin
      out_result <= acc_q;
      out_status <= st_q;
      out_len    <= ilte_pkg::LEN_W'(cnt_q);
    end
  end

  assign out_data = {{ilte_pkg::OUT_PAD{1'b0}}, out_len, out_status, out_result};

endmodule

`default_nettype wire

### design/ilte_ctrl.sv
// ----------------------------------------------------------------------------
// Indexed list table engine controller
// Sequences each request into reads, moves and writes on the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module ilte_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ilte_pkg::stat_t stat,
  output ilte_pkg::cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_GET,
    S_DEL_RD,
    S_DEL_MV,
    S_INS_MV,
    S_INS_WR,
    S_AGG,
    S_REV_A,
    S_REV_B,
    S_REV_C,
    S_REV_D,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // A request word is taken only when idle and out of reset.
  assign in_ready = (state == S_IDLE) && !rst;

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '{
      load:   1'b0,
      rd:     ilte_pkg::RD_PTR,
      wr:     ilte_pkg::WR_NONE,
      mv:     1'b0,
      agg:    1'b0,
      acc_ld: 1'b0,
      tmp_ld: 1'b0,
      st_ld:  1'b0,
      ptr:    ilte_pkg::PTR_HOLD,
      hi:     ilte_pkg::HI_HOLD,
      cnt:    ilte_pkg::CNT_HOLD,
      finish: 1'b0
    };
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end

      // Latch the status code and start the operation.
      S_DECODE: begin
        cmd.st_ld  = 1'b1;
        state_next = S_FINISH;
        if (stat.code == ilte_pkg::ST_OK) begin
          case (stat.op)
            ilte_pkg::OP_APPEND: begin
              cmd.wr  = ilte_pkg::WR_APPEND;
              cmd.cnt = ilte_pkg::CNT_INC;
            end
            ilte_pkg::OP_INSERT: begin
              cmd.ptr    = ilte_pkg::PTR_CNT;
              state_next = S_INS_MV;
            end
            ilte_pkg::OP_DELETE: begin
              cmd.rd     = ilte_pkg::RD_POS;
              cmd.ptr    = ilte_pkg::PTR_POS;
              state_next = S_DEL_RD;
            end
            ilte_pkg::OP_GET: begin
              cmd.rd     = ilte_pkg::RD_POS;
              state_next = S_GET;
            end
            ilte_pkg::OP_SET: begin
              cmd.wr = ilte_pkg::WR_POS_VAL;
            end
            ilte_pkg::OP_MAX, ilte_pkg::OP_MIN, ilte_pkg::OP_SUM: begin
              cmd.ptr    = ilte_pkg::PTR_ZERO;
              state_next = S_AGG;
            end
            ilte_pkg::OP_REVERSE: begin
              cmd.ptr    = ilte_pkg::PTR_ZERO;
              cmd.hi     = ilte_pkg::HI_CNT;
              state_next = S_REV_A;
            end
            default: state_next = S_FINISH;
          endcase
        end
      end

      S_GET: begin
        cmd.acc_ld = 1'b1;
        state_next = S_FINISH;
      end

      S_DEL_RD: begin
        cmd.acc_ld = 1'b1;
        state_next = S_DEL_MV;
      end

      // Shift down: read the entry above, write it one place lower next cycle.
      S_DEL_MV: begin
        if (stat.del_more) begin
          cmd.rd  = ilte_pkg::RD_PTR_INC;
          cmd.mv  = 1'b1;
          cmd.ptr = ilte_pkg::PTR_INC;
        end else begin
          cmd.cnt    = ilte_pkg::CNT_DEC;
          state_next = S_FINISH;
        end
      end

      // Shift up from the tail, then drop the new value into the gap.
      S_INS_MV: begin
        if (stat.ins_more) begin
          cmd.rd  = ilte_pkg::RD_PTR_DEC;
          cmd.mv  = 1'b1;
          cmd.ptr = ilte_pkg::PTR_DEC;
        end else begin
          state_next = S_INS_WR;
        end
      end

      S_INS_WR: begin
        cmd.wr     = ilte_pkg::WR_POS_VAL;
        cmd.cnt    = ilte_pkg::CNT_INC;
        state_next = S_FINISH;
      end

      // One entry read per cycle into the accumulator.
      S_AGG: begin
        if (stat.agg_more) begin
          cmd.agg = 1'b1;
          cmd.ptr = ilte_pkg::PTR_INC;
        end else begin
          state_next = S_FINISH;
        end
      end

      // Reverse: read low, read high, write low, write high.
      S_REV_A: begin
        if (stat.rev_more) begin
          state_next = S_REV_B;
        end else begin
          state_next = S_FINISH;
        end
      end

      S_REV_B: begin
        cmd.rd     = ilte_pkg::RD_HI;
        cmd.tmp_ld = 1'b1;
        state_next = S_REV_C;
      end

      S_REV_C: begin
        cmd.wr     = ilte_pkg::WR_PTR_RDATA;
        state_next = S_REV_D;
      end

      S_REV_D: begin
        cmd.wr  = ilte_pkg::WR_HI_TMP;
        cmd.ptr = ilte_pkg::PTR_INC;
        cmd.hi  = ilte_pkg::HI_DEC;
        if (stat.rev_next) begin
          cmd.rd     = ilte_pkg::RD_PTR_INC;
          state_next = S_REV_B;
        end else begin
          state_next = S_FINISH;
        end
      end

      // Hand the result to the output register once it is free.
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### design/indexed_list_table_engine_top.sv
// ----------------------------------------------------------------------------
// Indexed list table engine
// Ordered list of signed 32-bit entries with indexed and aggregate operations.
// ----------------------------------------------------------------------------
// Usage:
//   Each s_axis word (operation, position, value) yields exactly one m_axis
//   word (value, status, length after the operation). The capacity register
//   is to be written through cfg_valid/cfg_data only while the block is idle;
//   the block itself does not enforce this. cfg_ready is high whenever rst is
//   low. One request is handled at a time: a new word is not accepted before
//   the last one is finished. Append, get, set, errors and unknown codes
//   need no walk; with n the current length and p the position, insert and
//   delete walk the entries from p to the end, max, min and sum walk all n
//   entries, and reverse swaps entries in pairs from both ends. s_axis_tready
//   rises in the same cycle as m_axis_tvalid. Reset empties the list and sets
//   the capacity to 16; store contents are left as they were and are never
//   read before being written. If the receiver stalls, the result word holds
//   while the next request is accepted and processed; that one then waits for
//   the output register to be taken before it completes.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_table_engine_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Request word: operation[3:0], position[7:4], entry_value[39:8].
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [ilte_pkg::IN_W-1:0]     s_axis_tdata,
  // Result word: result_value[31:0], status[33:32], current_length[38:34].
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [ilte_pkg::OUT_W-1:0]    m_axis_tdata,
  // Capacity register write.
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ilte_pkg::CAP_W-1:0]    cfg_data
);

  ilte_pkg::cmd_t  cmd;
  ilte_pkg::stat_t stat;

  // The capacity register takes a write in any cycle outside reset.
  assign cfg_ready = !rst;

  ilte_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  ilte_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (s_axis_tdata),
    .cap_we   (cfg_valid & cfg_ready),
    .cap_data (cfg_data),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (m_axis_tdata)
  );

endmodule

`default_nettype wire

### design/ilte_checker.sv
// ----------------------------------------------------------------------------
// Indexed list table engine port checker
// Concurrent checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_list_table_engine_top_macros.svh"

module ilte_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       m_axis_tvalid,
  input wire logic                       m_axis_tready,
  input wire logic [ilte_pkg::OUT_W-1:0] m_axis_tdata
);

  // A stalled result word stays offered.
  `ILTE_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")

  // A stalled result word keeps its payload.
  `ILTE_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed while stalled")

  // Any error status carries a zero value.
  `ILTE_ASSERT(a_err_zero, m_axis_tvalid && (m_axis_tdata[33:32] != ilte_pkg::ST_OK) |-> (m_axis_tdata[31:0] == 32'd0), "error result with nonzero value")

  // The reported length never exceeds the store depth.
  `ILTE_ASSERT(a_len_bound, m_axis_tvalid |-> (m_axis_tdata[38:34] <= ilte_pkg::LEN_W'(ilte_pkg::STORE_DEPTH)), "length beyond store depth")

  // Nothing is offered in the cycle after reset.
  `ILTE_ASSERT_ALWAYS(a_rst_quiet, $past(rst) |-> !m_axis_tvalid, "result offered right after reset")

endmodule

bind indexed_list_table_engine_top ilte_checker u_ilte_checker (.*);

`default_nettype wire
